### rtl/core/lsfs_pkg.sv
// ----------------------------------------------------------------------------
// lsfs_pkg: shared types and codes of the led strip frame serializer
// Register indexes, protocol, channel order and brightness codes, the job
// descriptor passed from the front end to the byte sequencer.
// ----------------------------------------------------------------------------
package lsfs_pkg;

	// register indexes on the configuration port
	localparam logic [1:0] REG_PROTOCOL   = 2'd0;
	localparam logic [1:0] REG_ORDER      = 2'd1;
	localparam logic [1:0] REG_BRIGHTNESS = 2'd2;

	// protocol codes
	localparam logic [1:0] PROTO_NONE   = 2'd0;
	localparam logic [1:0] PROTO_STREAM = 2'd1;
	localparam logic [1:0] PROTO_FRAME  = 2'd2;

	// channel order codes, anything else gives gray
	localparam logic [2:0] ORDER_RGB = 3'd1;
	localparam logic [2:0] ORDER_RBG = 3'd2;
	localparam logic [2:0] ORDER_GRB = 3'd3;
	localparam logic [2:0] ORDER_GBR = 3'd4;
	localparam logic [2:0] ORDER_BRG = 3'd5;
	localparam logic [2:0] ORDER_BGR = 3'd6;

	// brightness codes, anything else counts as low
	localparam logic [2:0] BRIGHT_LOW  = 3'd1;
	localparam logic [2:0] BRIGHT_MED  = 3'd2;
	localparam logic [2:0] BRIGHT_HIGH = 3'd3;
	localparam logic [2:0] BRIGHT_FULL = 3'd4;

	// frame bytes
	localparam logic [7:0] HDR_MARK    = 8'hE0;
	localparam int         FRAME_ZEROS = 4;

	// short queue between front end and sequencer
	localparam int QUEUE_DEPTH = 2;
	localparam int QUEUE_AW    = 1;
	localparam int QUEUE_CW    = 2;

	typedef struct packed {
		logic [1:0] protocol;
		logic [2:0] order;
		logic [2:0] bright;
	} cfg_t;

	// one pixel, ready for the sequencer
	typedef struct packed {
		logic [7:0] c0;
		logic [7:0] c1;
		logic [7:0] c2;
		logic [7:0] header;
		logic       frame;
		logic       first;
		logic       last;
	} job_t;

endpackage

### rtl/core/lsfs_front.sv
// ----------------------------------------------------------------------------
// lsfs_front: pixel intake and colour preparation
// Accepts pixels, orders or greys the channels, tracks the pixel position,
// then scales stream bytes and builds the header for the sequencer.
// ----------------------------------------------------------------------------
module lsfs_front #(
	parameter int NUM_LEDS = 64
) (
	input  logic          clk,
	input  logic          arst_n,
	input  lsfs_pkg::cfg_t cfg,
	input  logic          push,
	output logic          full,
	input  logic [7:0]    red,
	input  logic [7:0]    green,
	input  logic [7:0]    blue,
	output logic          job_valid,
	input  logic          job_ready,
	output lsfs_pkg::job_t job
);
	import lsfs_pkg::*;

	localparam int          POS_W      = (NUM_LEDS > 1) ? $clog2(NUM_LEDS) : 1;
	localparam logic [POS_W-1:0] POS_LAST = POS_W'(NUM_LEDS - 1);
	localparam logic [19:0] GRAY_RECIP = 20'd683;

	logic             valid_s1;
	logic [7:0]       c0_s1, c1_s1, c2_s1;
	logic             frame_s1, first_s1, last_s1;
	logic [2:0]       bright_s1;
	logic [POS_W-1:0] pos_q;

	logic       s1_ready, load;
	logic [9:0] sum;
	logic [19:0] prod;
	logic [7:0] gray, c0_d, c1_d, c2_d;
	logic       pos_last;

	// brightness scaling of one stream byte
	function automatic logic [7:0] scale_byte(input logic [7:0] v, input logic [2:0] lvl);
		logic [7:0]  f;
		logic [7:0]  thr;
		logic [15:0] p;
		logic [7:0]  r;
		case (lvl)
			BRIGHT_HIGH: begin f = 8'd200; thr = 8'd1; end
			BRIGHT_MED:  begin f = 8'd100; thr = 8'd2; end
			default:     begin f = 8'd50;  thr = 8'd5; end
		endcase
		p = 16'(v) * 16'(f);
		if (lvl == BRIGHT_FULL || v == 8'd0)
			r = v;
		else if (v <= thr)
			r = 8'd1;
		else
			r = p[15:8];
		return r;
	endfunction

	// global brightness level of the frame header
	function automatic logic [4:0] header_level(input logic [2:0] lvl);
		logic [4:0] l;
		case (lvl)
			BRIGHT_FULL: l = 5'd31;
			BRIGHT_HIGH: l = 5'd20;
			BRIGHT_MED:  l = 5'd10;
			default:     l = 5'd5;
		endcase
		return l;
	endfunction

	// intake handshake, pixels with no protocol selected are dropped on entry
	assign s1_ready = !valid_s1 || job_ready;
	assign full     = !s1_ready;
	assign load     = push && s1_ready &&
	                  (cfg.protocol == PROTO_STREAM || cfg.protocol == PROTO_FRAME);
	assign pos_last = (pos_q == POS_LAST);

	// grey average by reciprocal multiply, exact for sums up to 765
	assign sum  = 10'(red) + 10'(green) + 10'(blue);
	assign prod = 20'(sum) * GRAY_RECIP;
	assign gray = prod[18:11];

	// channel permutation
	always_comb begin
		case (cfg.order)
			ORDER_RGB: begin c0_d = red;   c1_d = green; c2_d = blue;  end
			ORDER_RBG: begin c0_d = red;   c1_d = blue;  c2_d = green; end
			ORDER_GRB: begin c0_d = green; c1_d = red;   c2_d = blue;  end
			ORDER_GBR: begin c0_d = green; c1_d = blue;  c2_d = red;   end
			ORDER_BRG: begin c0_d = blue;  c1_d = red;   c2_d = green; end
			ORDER_BGR: begin c0_d = blue;  c1_d = green; c2_d = red;   end
			default:   begin c0_d = gray;  c1_d = gray;  c2_d = gray;  end
		endcase
	end

	// stage 1 control and pixel position
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			pos_q    <= '0;
		end else begin
			if (s1_ready)
				valid_s1 <= load;
			if (load)
				pos_q <= pos_last ? '0 : pos_q + POS_W'(1);
		end
	end

	// stage 1 payload
	always_ff @(posedge clk) begin
		if (load) begin
			c0_s1     <= c0_d;
			c1_s1     <= c1_d;
			c2_s1     <= c2_d;
			frame_s1  <= (cfg.protocol == PROTO_FRAME);
			first_s1  <= (pos_q == '0);
			last_s1   <= pos_last;
			bright_s1 <= cfg.bright;
		end
	end

	// scaling and header towards the queue
	assign job_valid  = valid_s1;
	assign job.c0     = frame_s1 ? c0_s1 : scale_byte(c0_s1, bright_s1);
	assign job.c1     = frame_s1 ? c1_s1 : scale_byte(c1_s1, bright_s1);
	assign job.c2     = frame_s1 ? c2_s1 : scale_byte(c2_s1, bright_s1);
	assign job.header = HDR_MARK | {3'b000, header_level(bright_s1)};
	assign job.frame  = frame_s1;
	assign job.first  = first_s1;
	assign job.last   = last_s1;

endmodule

### rtl/core/lsfs_queue.sv
// ----------------------------------------------------------------------------
// lsfs_queue: short job queue
// Two-entry queue of pixel jobs between the front end and the sequencer.
// ----------------------------------------------------------------------------
module lsfs_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	output logic           ready,
	input  lsfs_pkg::job_t  wr_job,
	output logic           valid,
	input  logic           take,
	output lsfs_pkg::job_t  rd_job
);
	import lsfs_pkg::*;

	job_t                mem_q [QUEUE_DEPTH];
	logic [QUEUE_AW-1:0] wr_ptr_q, rd_ptr_q;
	logic [QUEUE_CW-1:0] count_q;
	logic                do_push, do_take;

	assign ready   = (count_q < QUEUE_CW'(QUEUE_DEPTH));
	assign valid   = (count_q != '0);
	assign do_push = push && ready;
	assign do_take = take && valid;
	assign rd_job  = mem_q[rd_ptr_q];

	// pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push)
				wr_ptr_q <= wr_ptr_q + QUEUE_AW'(1);
			if (do_take)
				rd_ptr_q <= rd_ptr_q + QUEUE_AW'(1);
			if (do_push && !do_take)
				count_q <= count_q + QUEUE_CW'(1);
			else if (!do_push && do_take)
				count_q <= count_q - QUEUE_CW'(1);
		end
	end

	// storage
	always_ff @(posedge clk) begin
		if (do_push)
			mem_q[wr_ptr_q] <= wr_job;
	end

	a_fill_up: assert property (@(posedge clk) disable iff (!arst_n)
		do_push && !do_take |=> count_q == $past(count_q) + QUEUE_CW'(1))
		else $error("queue fill level did not rise on push");
	a_fill_down: assert property (@(posedge clk) disable iff (!arst_n)
		!do_push && do_take |=> count_q == $past(count_q) - QUEUE_CW'(1))
		else $error("queue fill level did not fall on take");
	a_ptr_gap: assert property (@(posedge clk) disable iff (!arst_n)
		QUEUE_AW'(wr_ptr_q - rd_ptr_q) == count_q[QUEUE_AW-1:0])
		else $error("queue pointers disagree with fill level");

endmodule

### rtl/core/lsfs_back.sv
// ----------------------------------------------------------------------------
// lsfs_back: strip byte sequencer
// Frame mode: start frame (first pixel), header, colours, end frame (last
// pixel); stream: colours. Output register takes one byte per cycle if free.
// ----------------------------------------------------------------------------
module lsfs_back #(
	parameter int NUM_LEDS = 64
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          job_valid,
	input  lsfs_pkg::job_t job,
	output logic          job_take,
	output logic          empty,
	input  logic          pop,
	output logic [7:0]    out_byte,
	output logic          last_of_run,
	output logic          end_of_frame
);
	import lsfs_pkg::*;

	localparam int TAIL_LEN = FRAME_ZEROS + NUM_LEDS / 16 + 1;
	localparam int CNT_W    = $clog2(TAIL_LEN);

	typedef enum logic [4:0] {
		PH_BEGIN = 5'b00001,
		PH_START = 5'b00010,
		PH_HEAD  = 5'b00100,
		PH_DATA  = 5'b01000,
		PH_TAIL  = 5'b10000
	} phase_t;

	phase_t           phase_q, cur, nxt;
	logic [CNT_W-1:0] cnt_q, cnt_d;
	logic             out_valid_q;
	logic [7:0]       out_byte_q;
	logic             last_q, eof_q;
	logic             emit, fin;
	logic [7:0]       byte_d;

	assign emit     = job_valid && (!out_valid_q || pop);
	assign job_take = emit && fin;

	// byte selection and step to the next byte
	always_comb begin
		if (phase_q == PH_BEGIN)
			cur = !job.frame ? PH_DATA : (job.first ? PH_START : PH_HEAD);
		else
			cur = phase_q;
		byte_d = 8'h00;
		fin    = 1'b0;
		nxt    = cur;
		cnt_d  = cnt_q + CNT_W'(1);
		case (cur)
			PH_START: begin
				if (cnt_q == CNT_W'(FRAME_ZEROS - 1)) begin
					nxt   = PH_HEAD;
					cnt_d = '0;
				end
			end
			PH_HEAD: begin
				byte_d = job.header;
				nxt    = PH_DATA;
				cnt_d  = '0;
			end
			PH_DATA: begin
				case (cnt_q[1:0])
					2'd0:    byte_d = job.c0;
					2'd1:    byte_d = job.c1;
					default: byte_d = job.c2;
				endcase
				if (cnt_q == CNT_W'(2)) begin
					fin   = !job.frame || !job.last;
					nxt   = PH_TAIL;
					cnt_d = '0;
				end
			end
			PH_TAIL: begin
				fin = (cnt_q == CNT_W'(TAIL_LEN - 1));
			end
			default: begin
				nxt = PH_BEGIN;
			end
		endcase
		if (fin) begin
			nxt   = PH_BEGIN;
			cnt_d = '0;
		end
	end

	// sequencer state and output register control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_BEGIN;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (emit) begin
				phase_q <= nxt;
				cnt_q   <= cnt_d;
			end
			out_valid_q <= emit || (out_valid_q && !pop);
		end
	end

	// output payload
	always_ff @(posedge clk) begin
		if (emit) begin
			out_byte_q <= byte_d;
			last_q     <= fin;
			eof_q      <= fin && job.last;
		end
	end

	assign empty        = !out_valid_q;
	assign out_byte     = out_byte_q;
	assign last_of_run  = last_q;
	assign end_of_frame = eof_q;

	a_eof_final: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && end_of_frame |-> last_of_run)
		else $error("end of frame without end of run");
	a_take_shows_final: assert property (@(posedge clk) disable iff (!arst_n)
		job_take |=> !empty && last_of_run)
		else $error("job retired without its final byte on the output");
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == PH_BEGIN && cnt_q == '0) ||
		(phase_q == PH_START && cnt_q <= CNT_W'(FRAME_ZEROS - 1)) ||
		(phase_q == PH_HEAD && cnt_q == '0) ||
		(phase_q == PH_DATA && cnt_q <= CNT_W'(2)) ||
		(phase_q == PH_TAIL && cnt_q <= CNT_W'(TAIL_LEN - 1)))
		else $error("byte counter out of range for its phase");

endmodule

### rtl/core/led_strip_frame_serializer.sv
// ----------------------------------------------------------------------------
// led_strip_frame_serializer: RGB pixels in, LED strip bytes out
// Pixels enter through a push/full queue port; strip bytes leave through an
// empty/pop queue port, one byte per pop, with last_of_run on the final byte
// of each pixel and end_of_frame on the final byte of the strip frame.
// Configuration (protocol, channel order, brightness) is written through
// cfg_we/cfg_index/cfg_data; the user must write it only while the block is
// idle, as the block does not enforce this. The sequencer puts out one byte
// per cycle while the receiver pops; a pixel is 3 bytes in stream mode and 4
// in frame mode; the first pixel of a frame adds 4 start bytes and the last
// adds 4 + NUM_LEDS/16 + 1 end bytes. The first byte of a pixel passes the
// intake stage, the queue and the output register in that order.
// Pixels arriving with no protocol selected are taken and dropped.
// Reset clears configuration, control state, pixel position and the queue.
// When the receiver stops popping, the output register holds its byte, the
// two-entry job queue and intake stage fill, and then full rises.
// ----------------------------------------------------------------------------
module led_strip_frame_serializer #(
	parameter int NUM_LEDS = 64
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_we,
	input  logic [1:0] cfg_index,
	input  logic [2:0] cfg_data,
	input  logic       push,
	output logic       full,
	input  logic [7:0] red,
	input  logic [7:0] green,
	input  logic [7:0] blue,
	output logic       empty,
	input  logic       pop,
	output logic [7:0] out_byte,
	output logic       last_of_run,
	output logic       end_of_frame
);
	import lsfs_pkg::*;

	cfg_t cfg_q;
	job_t front_job, back_job;
	logic front_valid, queue_ready, queue_valid, queue_take;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_PROTOCOL:   cfg_q.protocol <= cfg_data[1:0];
				REG_ORDER:      cfg_q.order    <= cfg_data;
				REG_BRIGHTNESS: cfg_q.bright   <= cfg_data;
				default: ;
			endcase
		end
	end

	lsfs_front #(
		.NUM_LEDS(NUM_LEDS)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.push      (push),
		.full      (full),
		.red       (red),
		.green     (green),
		.blue      (blue),
		.job_valid (front_valid),
		.job_ready (queue_ready),
		.job       (front_job)
	);

	lsfs_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (front_valid),
		.ready  (queue_ready),
		.wr_job (front_job),
		.valid  (queue_valid),
		.take   (queue_take),
		.rd_job (back_job)
	);

	lsfs_back #(
		.NUM_LEDS(NUM_LEDS)
	) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.job_valid    (queue_valid),
		.job          (back_job),
		.job_take     (queue_take),
		.empty        (empty),
		.pop          (pop),
		.out_byte     (out_byte),
		.last_of_run  (last_of_run),
		.end_of_frame (end_of_frame)
	);

endmodule
